[hw/rtl/alsl_pkg.sv]
package alsl_pkg;

	localparam int STALL_W   = 10;
	localparam int SPEED_W   = 24;
	localparam int THRESH_W  = 8;
	localparam int CLEAR_W   = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIMIT_ENABLED    = 3'd0,
		REG_DUAL_MODE        = 3'd1,
		REG_APPLIES_POSITIVE = 3'd2,
		REG_APPLIES_NEGATIVE = 3'd3,
		REG_STALL_CONFIRM    = 3'd4,
		REG_STALL_THRESHOLD  = 3'd5,
		REG_CLEARANCE_STEPS  = 3'd6
	} reg_idx_t;

	typedef enum logic {
		KIND_TICK    = 1'b0,
		KIND_SET_POS = 1'b1
	} kind_t;

	typedef struct packed {
		logic                limit_enabled;
		logic                dual_mode;
		logic                applies_positive;
		logic                applies_negative;
		logic                stall_confirm;
		logic [THRESH_W-1:0] stall_threshold;
		logic [CLEAR_W-1:0]  clearance_steps;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic               raw_min;
		logic               raw_max;
		logic [STALL_W-1:0] stall_value;
		logic               is_moving;
		logic               dir_positive;
		logic [SPEED_W-1:0] speed_now;
		logic [SPEED_W-1:0] speed_goal;
	} tick_t;

	typedef struct packed {
		logic seen_min;
		logic seen_max;
		logic allow_positive;
		logic allow_negative;
		logic anchor_was_positive;
	} flags_t;

	typedef struct packed {
		logic any_limit;
		logic may_go_positive;
		logic may_go_negative;
		logic stop_motion;
		logic position_fix;
		logic hit_event;
		logic hit_dir_positive;
	} res_t;

endpackage

[hw/rtl/alsl_cfg.sv]
module alsl_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [alsl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [alsl_pkg::CFG_DAT_W-1:0]     cfg_data,
	output alsl_pkg::cfg_t                     cfg
);

	alsl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				alsl_pkg::REG_LIMIT_ENABLED:    cfg_q.limit_enabled    <= cfg_data[0];
				alsl_pkg::REG_DUAL_MODE:        cfg_q.dual_mode        <= cfg_data[0];
				alsl_pkg::REG_APPLIES_POSITIVE: cfg_q.applies_positive <= cfg_data[0];
				alsl_pkg::REG_APPLIES_NEGATIVE: cfg_q.applies_negative <= cfg_data[0];
				alsl_pkg::REG_STALL_CONFIRM:    cfg_q.stall_confirm    <= cfg_data[0];
				alsl_pkg::REG_STALL_THRESHOLD:
					cfg_q.stall_threshold <= cfg_data[alsl_pkg::THRESH_W-1:0];
				alsl_pkg::REG_CLEARANCE_STEPS:
					cfg_q.clearance_steps <= cfg_data[alsl_pkg::CLEAR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/alsl_eval.sv]
module alsl_eval #(
	parameter int POSITION_WIDTH = 32
) (
	input  alsl_pkg::cfg_t                    cfg,
	input  alsl_pkg::tick_t                   tick,
	input  logic signed [POSITION_WIDTH-1:0]  pos,
	input  alsl_pkg::flags_t                  flags_q,
	input  logic signed [POSITION_WIDTH-1:0]  anchor_q,
	output alsl_pkg::flags_t                  flags_d,
	output logic signed [POSITION_WIDTH-1:0]  anchor_d,
	output alsl_pkg::res_t                    res,
	output logic signed [POSITION_WIDTH-1:0]  corr_pos,
	output logic signed [POSITION_WIDTH-1:0]  hit_at
);

	localparam int DW = (POSITION_WIDTH > alsl_pkg::CLEAR_W) ?
		POSITION_WIDTH + 1 : alsl_pkg::CLEAR_W + 1;

	always_comb begin
		logic                            tmin, tmax, active, changed, captured;
		logic                            dir_ok, confirmed, side;
		logic                            ap, an, awp, stop, fix, hit, hdir;
		logic signed [POSITION_WIDTH-1:0] p, anc, da, db;
		logic signed [POSITION_WIDTH:0]   d1;
		logic signed [DW-1:0]             span, clr;

		tmin     = 1'b0;
		tmax     = 1'b0;
		captured = 1'b0;
		stop     = 1'b0;
		fix      = 1'b0;
		hit      = 1'b0;
		hdir     = 1'b0;
		p        = pos;
		anc      = anchor_q;
		ap       = flags_q.allow_positive;
		an       = flags_q.allow_negative;
		awp      = flags_q.anchor_was_positive;
		flags_d  = flags_q;
		dir_ok   = tick.dir_positive ? cfg.applies_positive : cfg.applies_negative;
		confirmed = !(cfg.stall_confirm && tick.raw_min && tick.is_moving) ||
			(tick.stall_value <= {2'b00, cfg.stall_threshold});
		side     = tick.is_moving ? tick.dir_positive : flags_q.anchor_was_positive;
		da       = '0;
		db       = '0;
		d1       = '0;
		span     = '0;
		clr      = DW'({1'b0, cfg.clearance_steps});
		changed  = 1'b0;
		active   = 1'b0;

		if (tick.kind == alsl_pkg::KIND_SET_POS) begin
			anc = pos;
		end else if (cfg.limit_enabled) begin
			if (cfg.dual_mode) begin
				tmin = tick.raw_min;
				tmax = tick.raw_max;
			end else if (tick.raw_min && dir_ok && confirmed) begin
				tmin = !side;
				tmax = side;
			end
			active  = tmin || tmax;
			changed = (tmin != flags_q.seen_min) || (tmax != flags_q.seen_max);

			if (cfg.dual_mode) begin
				an = !tmin;
				ap = !tmax;
				if (changed && active && tick.is_moving) begin
					anc      = pos;
					awp      = tick.dir_positive;
					captured = 1'b1;
					hit      = 1'b1;
					hdir     = tmax;
				end
			end else begin
				if (changed) begin
					if (active && tick.is_moving && tick.speed_now != '0 &&
						tick.speed_now <= tick.speed_goal) begin
						anc      = pos;
						awp      = tick.dir_positive;
						captured = 1'b1;
						hit      = 1'b1;
						hdir     = tick.dir_positive;
						ap       = !tick.dir_positive;
						an       = tick.dir_positive;
					end else if (!active && !tick.is_moving && (!ap || !an)) begin
						if (pos != anc) begin
							p   = anc;
							fix = 1'b1;
						end
					end
				end
				da   = awp ? anc : p;
				db   = awp ? p : anc;
				d1   = {da[POSITION_WIDTH-1], da} - {db[POSITION_WIDTH-1], db};
				span = DW'(d1);
				if (!ap || !an) begin
					if (awp) begin
						an = 1'b1;
						if (span >= clr)
							ap = 1'b1;
					end else begin
						ap = 1'b1;
						if (span >= clr)
							an = 1'b1;
					end
				end
			end

			if (changed && active && tick.is_moving) begin
				if (!captured)
					anc = p;
				p    = anc;
				stop = 1'b1;
				fix  = 1'b1;
			end

			flags_d.seen_min            = tmin;
			flags_d.seen_max            = tmax;
			flags_d.allow_positive      = ap;
			flags_d.allow_negative      = an;
			flags_d.anchor_was_positive = awp;
		end

		anchor_d             = anc;
		corr_pos             = p;
		hit_at               = hit ? anc : '0;
		res.any_limit        = active;
		res.may_go_positive  = ap;
		res.may_go_negative  = an;
		res.stop_motion      = stop;
		res.position_fix     = fix;
		res.hit_event        = hit;
		res.hit_dir_positive = hdir;
	end

endmodule

[hw/rtl/axis_limit_stall_lockout.sv]
// Limit and stall lockout for one motion axis.
// Input channel (in_valid/in_ready): one item per control tick, either a limit
// sample with the motion status (kind 0) or a position set (kind 1).
// Output channel (out_valid/out_ready): exactly one result per input item, in
// order: permissions, stop command, corrected position and hit capture.
// Config channel (cfg_valid/cfg_ready): register index and data, always ready;
// write only while no item is in flight.
// A transfer on the input passes the input register, then the result
// register, on its way to the output. Throughput: one item per cycle while
// the receiver does not stall; the lockout state updates as an item enters
// the result register. When the receiver stalls, the result register holds,
// the input register fills, and in_ready drops only once both are occupied.
// Reset: all config registers read 0, both directions permitted, no limit seen,
// hit point 0, both pipeline stages empty.
module axis_limit_stall_lockout #(
	parameter int POSITION_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [alsl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [alsl_pkg::CFG_DAT_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 kind,
	input  logic                                 raw_min,
	input  logic                                 raw_max,
	input  logic [alsl_pkg::STALL_W-1:0]         stall_value,
	input  logic                                 is_moving,
	input  logic                                 dir_positive,
	input  logic [alsl_pkg::SPEED_W-1:0]         speed_now,
	input  logic [alsl_pkg::SPEED_W-1:0]         speed_goal,
	input  logic signed [POSITION_WIDTH-1:0]     position,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 any_limit,
	output logic                                 may_go_positive,
	output logic                                 may_go_negative,
	output logic                                 stop_motion,
	output logic                                 position_fix,
	output logic signed [POSITION_WIDTH-1:0]     corrected_position,
	output logic                                 hit_event,
	output logic                                 hit_dir_positive,
	output logic signed [POSITION_WIDTH-1:0]     hit_at
);

	alsl_pkg::cfg_t                    cfg;
	logic                              valid_s1, valid_s2, advance;
	alsl_pkg::tick_t                   tick_s1;
	logic signed [POSITION_WIDTH-1:0]  pos_s1;
	alsl_pkg::flags_t                  flags_q, flags_d;
	logic signed [POSITION_WIDTH-1:0]  anchor_q, anchor_d;
	alsl_pkg::res_t                    res_d, res_s2;
	logic signed [POSITION_WIDTH-1:0]  corr_d, corr_s2, hit_at_d, hit_at_s2;

	assign cfg_ready = 1'b1;

	alsl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tick_s1.kind         <= alsl_pkg::kind_t'(kind);
			tick_s1.raw_min      <= raw_min;
			tick_s1.raw_max      <= raw_max;
			tick_s1.stall_value  <= stall_value;
			tick_s1.is_moving    <= is_moving;
			tick_s1.dir_positive <= dir_positive;
			tick_s1.speed_now    <= speed_now;
			tick_s1.speed_goal   <= speed_goal;
			pos_s1               <= position;
		end
	end

	alsl_eval #(
		.POSITION_WIDTH (POSITION_WIDTH)
	) u_eval (
		.cfg      (cfg),
		.tick     (tick_s1),
		.pos      (pos_s1),
		.flags_q  (flags_q),
		.anchor_q (anchor_q),
		.flags_d  (flags_d),
		.anchor_d (anchor_d),
		.res      (res_d),
		.corr_pos (corr_d),
		.hit_at   (hit_at_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q  <= '{seen_min: 1'b0, seen_max: 1'b0, allow_positive: 1'b1,
				allow_negative: 1'b1, anchor_was_positive: 1'b0};
			anchor_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				flags_q  <= flags_d;
				anchor_q <= anchor_d;
			end
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2    <= res_d;
			corr_s2   <= corr_d;
			hit_at_s2 <= hit_at_d;
		end
	end

	assign out_valid          = valid_s2;
	assign any_limit          = res_s2.any_limit;
	assign may_go_positive    = res_s2.may_go_positive;
	assign may_go_negative    = res_s2.may_go_negative;
	assign stop_motion        = res_s2.stop_motion;
	assign position_fix       = res_s2.position_fix;
	assign corrected_position = corr_s2;
	assign hit_event          = res_s2.hit_event;
	assign hit_dir_positive   = res_s2.hit_dir_positive;
	assign hit_at             = hit_at_s2;

	a_stop_fixes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.stop_motion |-> res_s2.position_fix)
		else $error("stop without position fix");

	a_hit_pins: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.hit_event |-> res_s2.stop_motion && corr_s2 == hit_at_s2)
		else $error("hit not pinned to hit point");

	a_no_hit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.hit_event |-> !res_s2.hit_dir_positive && hit_at_s2 == '0)
		else $error("hit fields set without hit");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(flags_q) && $stable(anchor_q))
		else $error("lockout state changed without transfer");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(pos_s1))
		else $error("input stage lost item");

endmodule

[test/axis_limit_stall_lockout_tb.sv]
module axis_limit_stall_lockout_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POS_W       = 32;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 150;
	localparam int MAX_REPORTS = 10;

	localparam int STALL_W   = alsl_pkg::STALL_W;
	localparam int SPEED_W   = alsl_pkg::SPEED_W;
	localparam int THRESH_W  = alsl_pkg::THRESH_W;
	localparam int CLEAR_W   = alsl_pkg::CLEAR_W;
	localparam int CFG_IDX_W = alsl_pkg::CFG_IDX_W;
	localparam int CFG_DAT_W = alsl_pkg::CFG_DAT_W;

	localparam alsl_pkg::kind_t KIND_TICK    = alsl_pkg::KIND_TICK;
	localparam alsl_pkg::kind_t KIND_SET_POS = alsl_pkg::KIND_SET_POS;

	typedef struct packed {
		alsl_pkg::kind_t         kind;
		logic                    raw_min;
		logic                    raw_max;
		logic [STALL_W-1:0]      stall_value;
		logic                    is_moving;
		logic                    dir_positive;
		logic [SPEED_W-1:0]      speed_now;
		logic [SPEED_W-1:0]      speed_goal;
		logic signed [POS_W-1:0] position;
	} axis_tick_t;

	typedef struct packed {
		logic                    any_limit;
		logic                    may_go_positive;
		logic                    may_go_negative;
		logic                    stop_motion;
		logic                    position_fix;
		logic signed [POS_W-1:0] corrected_position;
		logic                    hit_event;
		logic                    hit_dir_positive;
		logic signed [POS_W-1:0] hit_at;
	} lockout_res_t;

	typedef struct packed {
		logic           new_cfg;
		alsl_pkg::cfg_t settings;
		axis_tick_t     item;
		logic           has_gold;
		lockout_res_t   gold;
	} plan_row_t;

	localparam logic         KEEP    = 1'b0;
	localparam logic         RELOAD  = 1'b1;
	localparam logic         PREDICT = 1'b0;
	localparam logic         GOLD    = 1'b1;
	localparam lockout_res_t NO_RES  = '0;

	localparam alsl_pkg::cfg_t CFG_OFF      = '0;
	localparam alsl_pkg::cfg_t CFG_DUAL     = {1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 24'd0};
	localparam alsl_pkg::cfg_t CFG_CONFIRM  = {1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'd255, 24'd10};
	localparam alsl_pkg::cfg_t CFG_NEG_ONLY = {1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0,
		24'hFFFFFF};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DAT_W-1:0]     cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     kind = 1'b0;
	logic                     raw_min = 1'b0;
	logic                     raw_max = 1'b0;
	logic [STALL_W-1:0]       stall_value = '0;
	logic                     is_moving = 1'b0;
	logic                     dir_positive = 1'b0;
	logic [SPEED_W-1:0]       speed_now = '0;
	logic [SPEED_W-1:0]       speed_goal = '0;
	logic signed [POS_W-1:0]  position = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     any_limit;
	logic                     may_go_positive;
	logic                     may_go_negative;
	logic                     stop_motion;
	logic                     position_fix;
	logic signed [POS_W-1:0]  corrected_position;
	logic                     hit_event;
	logic                     hit_dir_positive;
	logic signed [POS_W-1:0]  hit_at;

	axis_limit_stall_lockout #(.POSITION_WIDTH(POS_W)) DUT (.*);

	always #5 clk = ~clk;

	// lockout model state
	alsl_pkg::cfg_t          cfg = '0;
	logic                    seen_min = 1'b0;
	logic                    seen_max = 1'b0;
	logic                    allow_pos = 1'b1;
	logic                    allow_neg = 1'b1;
	logic                    anchor_dir = 1'b0;
	logic signed [POS_W-1:0] anchor_pos = '0;

	lockout_res_t expected_q[$];
	lockout_res_t want;
	plan_row_t    plan[$];

	int  cycle_cnt = 0;
	int  mismatches = 0;
	int  items_sent = 0;
	int  results_seen = 0;
	int  hits_seen = 0;
	int  stops_seen = 0;
	int  loads = 0;
	logic tx_burst = 1'b0;

	// random walk used to build well-formed tick sequences
	logic                    trk_min = 1'b0;
	logic                    trk_max = 1'b0;
	logic                    trk_dir = 1'b0;
	logic signed [POS_W-1:0] trk_pos = '0;

	function automatic logic coin(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 1;
		if (r < 85)
			return $urandom_range(2, 4);
		if (r < 95)
			return $urandom_range(5, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic axis_tick_t mk_tick(alsl_pkg::kind_t k, logic rmin, logic rmax,
			logic [STALL_W-1:0] st, logic mv, logic dr, logic [SPEED_W-1:0] now,
			logic [SPEED_W-1:0] goal, logic signed [POS_W-1:0] p);
		return {k, rmin, rmax, st, mv, dr, now, goal, p};
	endfunction

	function automatic lockout_res_t mk_res(logic lim, logic mp, logic mn, logic stp,
			logic fx, logic signed [POS_W-1:0] corr, logic ht, logic hd,
			logic signed [POS_W-1:0] hpos);
		return {lim, mp, mn, stp, fx, corr, ht, hd, hpos};
	endfunction

	function automatic lockout_res_t predict_lockout(axis_tick_t t);
		lockout_res_t            r;
		logic                    tmin, tmax, changed, captured, dir_ok, confirmed, side, active;
		logic signed [POS_W-1:0] p;
		logic signed [POS_W:0]   span;
		r = '0;
		tmin = 1'b0;
		tmax = 1'b0;
		changed = 1'b0;
		captured = 1'b0;
		p = t.position;
		if (t.kind == KIND_SET_POS) begin
			anchor_pos = p;
		end else if (cfg.limit_enabled) begin
			if (cfg.dual_mode) begin
				tmin = t.raw_min;
				tmax = t.raw_max;
			end else begin
				dir_ok = t.dir_positive ? cfg.applies_positive : cfg.applies_negative;
				confirmed = 1'b1;
				if (cfg.stall_confirm && t.raw_min && t.is_moving)
					confirmed = t.stall_value <= {2'b00, cfg.stall_threshold};
				if (t.raw_min && dir_ok && confirmed) begin
					side = t.is_moving ? t.dir_positive : anchor_dir;
					tmin = !side;
					tmax = side;
				end
			end
			changed = (tmin != seen_min) || (tmax != seen_max);
			seen_min = tmin;
			seen_max = tmax;
			active = tmin | tmax;
			if (cfg.dual_mode) begin
				allow_neg = !tmin;
				allow_pos = !tmax;
				if (changed && active && t.is_moving) begin
					anchor_pos = p;
					anchor_dir = t.dir_positive;
					captured = 1'b1;
					r.hit_event = 1'b1;
					r.hit_dir_positive = tmax;
				end
			end else begin
				if (changed) begin
					if (active && t.is_moving && t.speed_now != 0 &&
							t.speed_now <= t.speed_goal) begin
						anchor_pos = p;
						anchor_dir = t.dir_positive;
						captured = 1'b1;
						r.hit_event = 1'b1;
						r.hit_dir_positive = t.dir_positive;
						allow_pos = !t.dir_positive;
						allow_neg = t.dir_positive;
					end else if (!active && !t.is_moving && !(allow_pos && allow_neg) &&
							p != anchor_pos) begin
						p = anchor_pos;
						r.position_fix = 1'b1;
					end
				end
				// re-enable the blocked side once far enough back from the hit point
				if (!(allow_pos && allow_neg)) begin
					if (anchor_dir) begin
						allow_neg = 1'b1;
						span = {anchor_pos[POS_W-1], anchor_pos} - {p[POS_W-1], p};
						if (!span[POS_W] && span[POS_W-1:0] >= cfg.clearance_steps)
							allow_pos = 1'b1;
					end else begin
						allow_pos = 1'b1;
						span = {p[POS_W-1], p} - {anchor_pos[POS_W-1], anchor_pos};
						if (!span[POS_W] && span[POS_W-1:0] >= cfg.clearance_steps)
							allow_neg = 1'b1;
					end
				end
			end
			if (changed && active && t.is_moving) begin
				if (!captured)
					anchor_pos = p;
				p = anchor_pos;
				r.stop_motion = 1'b1;
				r.position_fix = 1'b1;
			end
			if (r.hit_event)
				r.hit_at = anchor_pos;
		end
		r.any_limit = tmin | tmax;
		r.may_go_positive = allow_pos;
		r.may_go_negative = allow_neg;
		r.corrected_position = p;
		return r;
	endfunction

	function automatic axis_tick_t random_tick();
		axis_tick_t  t;
		int unsigned step;
		t.kind = KIND_TICK;
		if (coin(8)) begin
			t.kind = alsl_pkg::kind_t'(coin(50));
			t.raw_min = coin(50);
			t.raw_max = coin(50);
			t.stall_value = STALL_W'($urandom);
			t.is_moving = coin(50);
			t.dir_positive = coin(50);
			t.speed_now = SPEED_W'($urandom);
			t.speed_goal = SPEED_W'($urandom);
			t.position = $urandom;
			return t;
		end
		if (coin(15))
			trk_min = !trk_min;
		if (coin(12))
			trk_max = !trk_max;
		if (coin(10))
			trk_dir = !trk_dir;
		t.raw_min = trk_min;
		t.raw_max = trk_max;
		t.dir_positive = trk_dir;
		t.is_moving = coin(80);
		t.stall_value = coin(70) ? STALL_W'($urandom_range(0, cfg.stall_threshold)) :
			STALL_W'($urandom);
		t.speed_goal = coin(50) ? SPEED_W'($urandom_range(1, 1000)) : SPEED_W'($urandom);
		if (coin(85))
			t.speed_now = SPEED_W'($urandom_range(1, t.speed_goal));
		else
			t.speed_now = coin(50) ? '0 : SPEED_W'($urandom);
		step = $urandom_range(0, cfg.clearance_steps / 4 + 3);
		if (coin(3))
			trk_pos = $urandom;
		else if (t.is_moving)
			trk_pos = trk_dir ? trk_pos + step : trk_pos - step;
		if (coin(5)) begin
			t.kind = KIND_SET_POS;
			if (coin(40))
				trk_pos = $urandom;
		end
		t.position = trk_pos;
		return t;
	endfunction

	task automatic send_tick(axis_tick_t t, logic has_gold, lockout_res_t gold);
		int           gap;
		lockout_res_t pred;
		if ($urandom_range(0, 63) == 0)
			tx_burst = !tx_burst;
		gap = (tx_burst || coin(65)) ? 0 : idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= t.kind;
		raw_min <= t.raw_min;
		raw_max <= t.raw_max;
		stall_value <= t.stall_value;
		is_moving <= t.is_moving;
		dir_positive <= t.dir_positive;
		speed_now <= t.speed_now;
		speed_goal <= t.speed_goal;
		position <= t.position;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = predict_lockout(t);
		expected_q.push_back(has_gold ? gold : pred);
		items_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_settings(alsl_pkg::cfg_t c);
		alsl_pkg::reg_idx_t   idx;
		logic [CFG_DAT_W-1:0] d;
		for (int i = int'(alsl_pkg::REG_LIMIT_ENABLED);
				i <= int'(alsl_pkg::REG_CLEARANCE_STEPS); i++) begin
			idx = alsl_pkg::reg_idx_t'(i);
			case (idx)
				alsl_pkg::REG_LIMIT_ENABLED:    d = {23'd0, c.limit_enabled};
				alsl_pkg::REG_DUAL_MODE:        d = {23'd0, c.dual_mode};
				alsl_pkg::REG_APPLIES_POSITIVE: d = {23'd0, c.applies_positive};
				alsl_pkg::REG_APPLIES_NEGATIVE: d = {23'd0, c.applies_negative};
				alsl_pkg::REG_STALL_CONFIRM:    d = {23'd0, c.stall_confirm};
				alsl_pkg::REG_STALL_THRESHOLD:  d = {16'd0, c.stall_threshold};
				alsl_pkg::REG_CLEARANCE_STEPS:  d = c.clearance_steps;
				default:                        d = '0;
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= d;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		cfg = c;
		loads++;
	endtask

	task automatic note_field(string name, logic [POS_W-1:0] e, logic [POS_W-1:0] a);
		if (a !== e) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("cycle %0d %s: expected %h, got %h", cycle_cnt, name, e, a);
		end
	endtask

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_cnt,
				expected_q.size());
			$display("FAIL axis_limit_stall_lockout");
			$finish;
		end
	end

	int rx_hold = 0;
	int rx_calm = 0;

	always @(posedge clk) begin
		if (rx_calm != 0)
			rx_calm--;
		else if ($urandom_range(0, 299) == 0)
			rx_calm = $urandom_range(50, 300);
		if (rx_hold != 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if (rx_calm == 0 && coin(25)) begin
			rx_hold = idle_len() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (hit_event)
				hits_seen++;
			if (stop_motion)
				stops_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("cycle %0d: result transfer with nothing expected", cycle_cnt);
			end else begin
				want = expected_q.pop_front();
				note_field("any_limit", POS_W'(want.any_limit), POS_W'(any_limit));
				note_field("may_go_positive", POS_W'(want.may_go_positive),
					POS_W'(may_go_positive));
				note_field("may_go_negative", POS_W'(want.may_go_negative),
					POS_W'(may_go_negative));
				note_field("stop_motion", POS_W'(want.stop_motion), POS_W'(stop_motion));
				note_field("position_fix", POS_W'(want.position_fix), POS_W'(position_fix));
				note_field("corrected_position", want.corrected_position, corrected_position);
				note_field("hit_event", POS_W'(want.hit_event), POS_W'(hit_event));
				note_field("hit_dir_positive", POS_W'(want.hit_dir_positive),
					POS_W'(hit_dir_positive));
				note_field("hit_at", want.hit_at, hit_at);
			end
		end
	end

	initial begin
		alsl_pkg::cfg_t c;
		int             pause_at;

		// disabled: nothing reported, set-position re-anchors
		plan.push_back({RELOAD, CFG_OFF, mk_tick(KIND_TICK, 1'b1, 1'b1, 10'd1023, 1'b1, 1'b1,
			24'hFFFFFF, 24'hFFFFFF, 32'sh7FFFFFFF), GOLD, mk_res(1'b0, 1'b1, 1'b1, 1'b0,
			1'b0, 32'sh7FFFFFFF, 1'b0, 1'b0, 32'sd0)});
		plan.push_back({KEEP, CFG_OFF, mk_tick(KIND_SET_POS, 1'b1, 1'b1, 10'd0, 1'b1, 1'b0,
			24'd0, 24'd0, 32'sh80000000), GOLD, mk_res(1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
			32'sh80000000, 1'b0, 1'b0, 32'sd0)});
		// dual mode: each input blocks its own side
		plan.push_back({RELOAD, CFG_DUAL, mk_tick(KIND_TICK, 1'b1, 1'b0, 10'd0, 1'b1, 1'b0,
			24'd0, 24'd0, 32'sd100), GOLD, mk_res(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 32'sd100,
			1'b1, 1'b0, 32'sd100)});
		plan.push_back({KEEP, CFG_DUAL, mk_tick(KIND_TICK, 1'b1, 1'b1, 10'd0, 1'b1, 1'b1,
			24'd0, 24'd0, 32'sd200), GOLD, mk_res(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 32'sd200,
			1'b1, 1'b1, 32'sd200)});
		plan.push_back({KEEP, CFG_DUAL, mk_tick(KIND_TICK, 1'b1, 1'b1, 10'd0, 1'b1, 1'b1,
			24'd0, 24'd0, 32'sd300), GOLD, mk_res(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd300,
			1'b0, 1'b0, 32'sd0)});
		plan.push_back({KEEP, CFG_DUAL, mk_tick(KIND_TICK, 1'b0, 1'b0, 10'd0, 1'b0, 1'b1,
			24'd0, 24'd0, 32'sd5), GOLD, mk_res(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 32'sd5,
			1'b0, 1'b0, 32'sd0)});
		plan.push_back({KEEP, CFG_DUAL, mk_tick(KIND_TICK, 1'b1, 1'b0, 10'd0, 1'b0, 1'b0,
			24'd7, 24'd9, -32'sd40), PREDICT, NO_RES});
		plan.push_back({KEEP, CFG_DUAL, mk_tick(KIND_TICK, 1'b0, 1'b0, 10'd0, 1'b1, 1'b1,
			24'd7, 24'd9, -32'sd41), PREDICT, NO_RES});
		// single source with stall confirmation and a clearance of 10
		plan.push_back({RELOAD, CFG_CONFIRM, mk_tick(KIND_TICK, 1'b1, 1'b0, 10'd1023, 1'b1,
			1'b1, 24'd5, 24'd5, 32'sd1000), GOLD, mk_res(1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
			32'sd1000, 1'b0, 1'b0, 32'sd0)});
		plan.push_back({KEEP, CFG_CONFIRM, mk_tick(KIND_TICK, 1'b1, 1'b0, 10'd0, 1'b1, 1'b1,
			24'd5, 24'd5, 32'sd1000), GOLD, mk_res(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 32'sd1000,
			1'b1, 1'b1, 32'sd1000)});
		plan.push_back({KEEP, CFG_CONFIRM, mk_tick(KIND_TICK, 1'b0, 1'b0, 10'd0, 1'b0, 1'b1,
			24'd0, 24'd0, 32'sd1003), GOLD, mk_res(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 32'sd1000,
			1'b0, 1'b0, 32'sd0)});
		plan.push_back({KEEP, CFG_CONFIRM, mk_tick(KIND_TICK, 1'b0, 1'b0, 10'd1023, 1'b1,
			1'b0, 24'd3, 24'd4, 32'sd990), GOLD, mk_res(1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
			32'sd990, 1'b0, 1'b0, 32'sd0)});
		plan.push_back({KEEP, CFG_CONFIRM, mk_tick(KIND_TICK, 1'b1, 1'b0, 10'd255, 1'b1,
			1'b0, 24'd0, 24'd0, -32'sd50), PREDICT, NO_RES});
		plan.push_back({KEEP, CFG_CONFIRM, mk_tick(KIND_TICK, 1'b1, 1'b0, 10'd1023, 1'b0,
			1'b1, 24'd0, 24'd0, 32'sh7FFFFFFF), PREDICT, NO_RES});
		plan.push_back({KEEP, CFG_CONFIRM, mk_tick(KIND_TICK, 1'b1, 1'b1, 10'd1, 1'b1, 1'b1,
			24'd6, 24'd5, 32'sd77), PREDICT, NO_RES});
		plan.push_back({KEEP, CFG_CONFIRM, mk_tick(KIND_TICK, 1'b0, 1'b0, 10'd1, 1'b1, 1'b1,
			24'd6, 24'd5, 32'sd90), PREDICT, NO_RES});
		// single source, negative side only, widest clearance
		plan.push_back({RELOAD, CFG_NEG_ONLY, mk_tick(KIND_TICK, 1'b1, 1'b0, 10'd0, 1'b1,
			1'b1, 24'd2, 24'd3, 32'sd0), PREDICT, NO_RES});
		plan.push_back({KEEP, CFG_NEG_ONLY, mk_tick(KIND_TICK, 1'b1, 1'b0, 10'd1023, 1'b1,
			1'b0, 24'hFFFFFF, 24'hFFFFFF, 32'sh80000000), PREDICT, NO_RES});
		plan.push_back({KEEP, CFG_NEG_ONLY, mk_tick(KIND_TICK, 1'b0, 1'b0, 10'd0, 1'b1, 1'b1,
			24'd1, 24'd1, 32'sh7FFFFFFF), PREDICT, NO_RES});
		plan.push_back({KEEP, CFG_NEG_ONLY, mk_tick(KIND_SET_POS, 1'b0, 1'b1, 10'd0, 1'b0,
			1'b0, 24'd0, 24'd0, 32'sd0), PREDICT, NO_RES});
		plan.push_back({KEEP, CFG_NEG_ONLY, mk_tick(KIND_TICK, 1'b1, 1'b0, 10'd1023, 1'b1,
			1'b0, 24'd1, 24'd1, 32'sd12345), PREDICT, NO_RES});
		plan.push_back({KEEP, CFG_NEG_ONLY, mk_tick(KIND_TICK, 1'b0, 1'b0, 10'd0, 1'b0,
			1'b0, 24'd0, 24'd0, 32'sd0), PREDICT, NO_RES});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].new_cfg) begin
				wait_idle();
				load_settings(plan[i].settings);
			end
			send_tick(plan[i].item, plan[i].has_gold, plan[i].gold);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			c.limit_enabled = coin(85);
			c.dual_mode = coin(30);
			c.applies_positive = coin(75);
			c.applies_negative = coin(75);
			c.stall_confirm = coin(50);
			case ($urandom_range(0, 2))
				0:       c.stall_threshold = '0;
				1:       c.stall_threshold = '1;
				default: c.stall_threshold = THRESH_W'($urandom);
			endcase
			case ($urandom_range(0, 3))
				0:       c.clearance_steps = '0;
				1:       c.clearance_steps = '1;
				2:       c.clearance_steps = CLEAR_W'($urandom_range(1, 40));
				default: c.clearance_steps = CLEAR_W'($urandom);
			endcase
			wait_idle();
			load_settings(c);
			tx_burst = coin(30);
			pause_at = $urandom_range(20, PHASE_ITEMS - 20);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == pause_at)
					wait_idle();
				send_tick(random_tick(), PREDICT, NO_RES);
			end
		end

		wait_idle();
		repeat (6) @(posedge clk);

		$display("Sent %0d items under %0d register settings; %0d results checked",
			items_sent, loads, results_seen);
		$display("Results carried %0d hit captures and %0d stop commands; %0d mismatches",
			hits_seen, stops_seen, mismatches);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("PASS axis_limit_stall_lockout");
		end else begin
			$display("FAIL axis_limit_stall_lockout");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/alsl_pkg.sv
hw/rtl/alsl_cfg.sv
hw/rtl/alsl_eval.sv
hw/rtl/axis_limit_stall_lockout.sv
test/axis_limit_stall_lockout_tb.sv
